// File: rtl/pnr_pkg.sv
// ----------------------------------------------------------------------------
// pnr_pkg
// shared constants, types and helpers for the polynomial newton root unit
// ----------------------------------------------------------------------------
`default_nettype none
package pnr_pkg;
   localparam int MaxDegree = 5;
   localparam int FracBits  = 16;
   localparam int NumCoeff  = 6;
   localparam int NumRegs   = 8;
   localparam int AddrBits  = 5;

   localparam logic [2:0] RegTolerance = 3'd6;
   localparam logic [2:0] RegMaxSteps  = 3'd7;

   localparam logic [1:0] StatusConverged = 2'd0;
   localparam logic [1:0] StatusStepLimit = 2'd1;
   localparam logic [1:0] StatusZeroSlope = 2'd2;

   localparam logic [30:0] ToleranceReset = 31'd1;
   localparam logic [15:0] MaxStepsReset  = 16'd1000;

   typedef logic signed [31:0] fixed_type;

   // saturate a signed 66-bit value to 32 bits
   function automatic fixed_type sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) begin
         sat32 = 32'sh7fffffff;
      end else if (v < -66'sd2147483648) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction
endpackage
`default_nettype wire

// File: rtl/polynomial_newton_root_unit.sv
// ----------------------------------------------------------------------------
// polynomial_newton_root_unit
// newton iteration on a degree-5 polynomial in signed q15.16
// ----------------------------------------------------------------------------
// operation: each newton step runs the value, slope, divide, and check and update phases in turn,
// the value and slope on the one shared multiply-add unit and the divide on the bit-serial divider
// throughput: one transaction at a time; req_tready is low while a search runs
// and while a finished result waits behind an unaccepted one
// reset: synchronous active high; coefficients clear, tolerance 1, max_steps 1000
`default_nettype none
module polynomial_newton_root_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [31:0] req_tdata,   // start_point
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [55:0] rsp_tdata,   // root[31:0], status[33:32], steps_used[50:34]
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);
   typedef enum logic [3:0] {
      ST_IDLE, ST_VLOAD, ST_VWAIT, ST_CHECK, ST_SLOAD, ST_SWAIT,
      ST_SCHECK, ST_DIV, ST_UPDATE, ST_OUT
   } state_type;

   state_type state_ff;
   pnr_pkg::fixed_type coeff_ff [pnr_pkg::NumCoeff];
   logic [30:0] tol_ff;
   logic [15:0] max_ff;
   pnr_pkg::fixed_type x_ff, acc_ff, f_ff, slope_ff;
   logic [16:0] n_ff;
   logic [2:0] k_ff;
   logic [1:0] status_ff;
   logic rsp_valid_ff;
   logic [2:0] reg_idx;
   logic csr_wr;

   // mac operands
   pnr_pkg::fixed_type mac_add, mac_res, dq;
   logic mac_load, div_start, div_done;
   logic [32:0] abs_f;

   assign csr_pready = 1'b1;
   assign reg_idx = csr_paddr[4:2];
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (reg_idx)
         pnr_pkg::RegTolerance: csr_prdata = {1'b0, tol_ff};
         pnr_pkg::RegMaxSteps: csr_prdata = {16'd0, max_ff};
         default: csr_prdata = (reg_idx < 3'(pnr_pkg::NumCoeff)) ? coeff_ff[reg_idx] : '0;
      endcase
   end

   // derivative term k*coeff_k, saturated
   function automatic pnr_pkg::fixed_type dterm(input logic [2:0] k,
                                                input pnr_pkg::fixed_type c);
      dterm = pnr_pkg::sat32(66'(c) * 66'(signed'({1'b0, k})));
   endfunction

   always_comb begin
      mac_load = (state_ff == ST_VLOAD) || (state_ff == ST_SLOAD);
      if (state_ff == ST_VLOAD) begin
         mac_add = coeff_ff[k_ff];
      end else begin
         mac_add = dterm(k_ff, coeff_ff[k_ff]);
      end
      abs_f = f_ff[31] ? -33'(f_ff) : 33'(f_ff);
      div_start = (state_ff == ST_SCHECK) && (slope_ff != 0);
   end

   pnr_mac u_mac (.clock(clock), .load(mac_load), .acc(acc_ff), .x(x_ff),
                  .addend(mac_add), .result(mac_res));

   pnr_div u_div (.clock(clock), .reset(reset), .start(div_start), .num(f_ff),
                  .den(slope_ff), .done(div_done), .quot(dq));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         tol_ff <= pnr_pkg::ToleranceReset;
         max_ff <= pnr_pkg::MaxStepsReset;
         for (int i = 0; i < pnr_pkg::NumCoeff; i++) coeff_ff[i] <= '0;
      end else begin
         if (csr_wr) begin
            if (reg_idx < 3'(pnr_pkg::NumCoeff)) coeff_ff[reg_idx] <= csr_pwdata;
            else if (reg_idx == pnr_pkg::RegTolerance) tol_ff <= csr_pwdata[30:0];
            else if (reg_idx == pnr_pkg::RegMaxSteps) max_ff <= csr_pwdata[15:0];
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  x_ff <= req_tdata;
                  n_ff <= '0;
                  acc_ff <= coeff_ff[pnr_pkg::MaxDegree];
                  k_ff <= 3'(pnr_pkg::MaxDegree - 1);
                  state_ff <= ST_VLOAD;
               end
            end
            ST_VLOAD: state_ff <= ST_VWAIT;
            ST_VWAIT: begin
               acc_ff <= mac_res;
               if (k_ff == 3'd0) begin
                  f_ff <= mac_res;
                  state_ff <= ST_CHECK;
               end else begin
                  k_ff <= k_ff - 3'd1;
                  state_ff <= ST_VLOAD;
               end
            end
            ST_CHECK: begin
               if (abs_f <= {2'b00, tol_ff}) begin
                  status_ff <= pnr_pkg::StatusConverged;
                  state_ff <= ST_OUT;
               end else if (n_ff > {1'b0, max_ff}) begin
                  status_ff <= pnr_pkg::StatusStepLimit;
                  state_ff <= ST_OUT;
               end else begin
                  acc_ff <= dterm(3'(pnr_pkg::MaxDegree), coeff_ff[pnr_pkg::MaxDegree]);
                  k_ff <= 3'(pnr_pkg::MaxDegree - 1);
                  state_ff <= ST_SLOAD;
               end
            end
            ST_SLOAD: state_ff <= ST_SWAIT;
            ST_SWAIT: begin
               acc_ff <= mac_res;
               if (k_ff == 3'd1) begin
                  slope_ff <= mac_res;
                  state_ff <= ST_SCHECK;
               end else begin
                  k_ff <= k_ff - 3'd1;
                  state_ff <= ST_SLOAD;
               end
            end
            ST_SCHECK: begin
               if (slope_ff == 0) begin
                  status_ff <= pnr_pkg::StatusZeroSlope;
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: if (div_done) state_ff <= ST_UPDATE;
            ST_UPDATE: begin
               x_ff <= pnr_pkg::sat32(66'(x_ff) - 66'(dq));
               n_ff <= n_ff + 17'd1;
               acc_ff <= coeff_ff[pnr_pkg::MaxDegree];
               k_ff <= 3'(pnr_pkg::MaxDegree - 1);
               state_ff <= ST_VLOAD;
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         if (rsp_valid_ff && rsp_tready && state_ff != ST_OUT) rsp_valid_ff <= 1'b0;
      end
   end

   // result register; the next search may start while it waits
   logic [55:0] out_ff;
   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && (!rsp_valid_ff || rsp_tready)) begin
         out_ff <= {5'd0, n_ff, status_ff, x_ff};
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = out_ff;
endmodule
`default_nettype wire

// File: rtl/pnr_mac.sv
// ----------------------------------------------------------------------------
// pnr_mac
// shared horner step: registered product, then truncate, saturate and add
// ----------------------------------------------------------------------------
`default_nettype none
module pnr_mac (
   input  wire logic              clock,
   input  wire logic              load,
   input  wire pnr_pkg::fixed_type acc,
   input  wire pnr_pkg::fixed_type x,
   input  wire pnr_pkg::fixed_type addend,
   output      pnr_pkg::fixed_type result
);
   logic signed [63:0] prod_ff;
   pnr_pkg::fixed_type addend_ff;
   logic signed [63:0] mag;
   logic signed [63:0] shifted;
   pnr_pkg::fixed_type trunc;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff   <= 64'(acc) * 64'(x);
         addend_ff <= addend;
      end
   end

   // truncate toward zero
   always_comb begin
      mag = prod_ff[63] ? -prod_ff : prod_ff;
      shifted = mag >>> pnr_pkg::FracBits;
      if (prod_ff[63]) begin
         shifted = -shifted;
      end
      trunc = pnr_pkg::sat32(66'(shifted));
      result = pnr_pkg::sat32(66'(trunc) + 66'(addend_ff));
   end
endmodule
`default_nettype wire

// File: rtl/pnr_div.sv
// ----------------------------------------------------------------------------
// pnr_div
// restoring divider, one quotient bit per cycle, truncating, saturated
// ----------------------------------------------------------------------------
`default_nettype none
module pnr_div (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire pnr_pkg::fixed_type num,
   input  wire pnr_pkg::fixed_type den,
   output      logic              done,
   output      pnr_pkg::fixed_type quot
);
   localparam int NBits = 32 + pnr_pkg::FracBits;
   logic [NBits-1:0] q_ff, q_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] d_ff, d_in;
   logic neg_ff, neg_in;
   logic busy_ff, busy_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [32:0] trial;
   logic signed [65:0] sq;

   always_comb begin
      q_in = q_ff; rem_in = rem_ff; d_in = d_ff; neg_in = neg_ff;
      busy_in = busy_ff; cnt_in = cnt_ff;
      trial = '0;
      if (start) begin
         q_in = NBits'(num[31] ? -33'(num) : 33'(num)) << pnr_pkg::FracBits;
         d_in = den[31] ? 32'(-33'(den)) : den;
         neg_in = num[31] ^ den[31];
         rem_in = '0;
         busy_in = 1'b1;
         cnt_in = 6'(NBits);
      end else if (busy_ff) begin
         if (cnt_ff == 6'd0) begin
            // quotient held for one cycle while done is high
            busy_in = 1'b0;
         end else begin
            trial = {rem_ff[31:0], q_ff[NBits-1]};
            q_in = {q_ff[NBits-2:0], 1'b0};
            if (trial >= {1'b0, d_ff}) begin
               rem_in = trial - {1'b0, d_ff};
               q_in[0] = 1'b1;
            end else begin
               rem_in = trial;
            end
            cnt_in = cnt_ff - 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in; rem_ff <= rem_in; d_ff <= d_in; neg_ff <= neg_in;
   end

   always_comb begin
      sq = neg_ff ? -66'(q_ff) : 66'(q_ff);
      quot = pnr_pkg::sat32(sq);
      done = busy_ff && (cnt_ff == 6'd0);
   end
endmodule
`default_nettype wire

// File: rtl/pnr_checker.sv
// ----------------------------------------------------------------------------
// pnr_sva
// port-level checks for the polynomial newton root unit
// ----------------------------------------------------------------------------
`default_nettype none
module pnr_sva (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [55:0] rsp_tdata
);
   // a held result keeps its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp payload changed while stalled");
   // status code never takes the unused value
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[33:32] != 2'd3)
      else $error("bad status");
   // one transaction at a time: no new request right after acceptance
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("ready after accept");
endmodule

bind polynomial_newton_root_unit pnr_sva u_pnr_sva (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));
`default_nettype wire

// File: verif/pnr_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pnr_checker
// watches the request, response and register ports of the newton root unit,
// predicts each search result and compares it field by field
// ----------------------------------------------------------------------------
`default_nettype none
module pnr_checker
   import pnr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [31:0] req_tdata,   // start_point
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [55:0] rsp_tdata,   // root, status, steps_used
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic        csr_pready,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      int          error_count,
   output      int          pending_count
);
   typedef struct packed {
      logic [16:0] steps;
      logic [1:0]  status;
      logic [31:0] root;
   } search_result_type;

   logic signed [63:0] coeff [NumCoeff];
   logic [30:0]        tol;
   logic [15:0]        step_limit;
   search_result_type  expected_q [$];

   function automatic fixed_type sat64(input logic signed [63:0] v);
      return sat32(66'(v));
   endfunction

   function automatic fixed_type fx_mul(input fixed_type a, input fixed_type b);
      logic signed [63:0] p, r;
      p = 64'(a) * 64'(b);
      if (p < 0) r = -((-p) >>> FracBits);
      else r = p >>> FracBits;
      return sat64(r);
   endfunction

   function automatic fixed_type poly_value(input fixed_type x);
      fixed_type acc;
      acc = sat64(coeff[MaxDegree]);
      for (int k = MaxDegree - 1; k >= 0; k--)
         acc = sat64(64'(fx_mul(acc, x)) + coeff[k]);
      return acc;
   endfunction

   function automatic fixed_type poly_slope(input fixed_type x);
      fixed_type acc;
      acc = sat64(64'(MaxDegree) * coeff[MaxDegree]);
      for (int k = MaxDegree - 1; k >= 1; k--)
         acc = sat64(64'(fx_mul(acc, x)) + sat64(64'(k) * coeff[k]));
      return acc;
   endfunction

   function automatic search_result_type newton_search(input fixed_type start);
      search_result_type res;
      fixed_type x, f, d, q;
      logic signed [63:0] af;
      int unsigned n;
      x = start;
      n = 0;
      forever begin
         f = poly_value(x);
         af = (f < 0) ? -64'(f) : 64'(f);
         if (af <= 64'(tol)) begin
            res.status = StatusConverged;
            break;
         end
         if (n > step_limit) begin
            res.status = StatusStepLimit;
            break;
         end
         d = poly_slope(x);
         if (d == 0) begin
            res.status = StatusZeroSlope;
            break;
         end
         q = sat64((64'(f) <<< FracBits) / 64'(d));
         x = sat64(64'(x) - 64'(q));
         n++;
      end
      res.root = x;
      res.steps = n[16:0];
      return res;
   endfunction

   assign pending_count = expected_q.size();

   always @(posedge clock) begin
      search_result_type exp_r, got;
      int errs;
      errs = 0;
      if (reset) begin
         for (int k = 0; k < NumCoeff; k++) coeff[k] <= 0;
         tol <= ToleranceReset;
         step_limit <= MaxStepsReset;
         expected_q.delete();
         error_count <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[4:2] < NumCoeff) coeff[csr_paddr[4:2]] <= 64'(signed'(csr_pwdata));
            else if (csr_paddr[4:2] == RegTolerance) tol <= csr_pwdata[30:0];
            else if (csr_paddr[4:2] == RegMaxSteps) step_limit <= csr_pwdata[15:0];
         end
         if (req_tvalid && req_tready) expected_q.push_back(newton_search(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[50:0];
            if (expected_q.size() == 0) begin
               $error("unexpected response root=%h", got.root);
               errs++;
            end else begin
               exp_r = expected_q.pop_front();
               if (got.root !== exp_r.root) begin
                  $error("root expected %h actual %h", exp_r.root, got.root);
                  errs++;
               end
               if (got.status !== exp_r.status) begin
                  $error("status expected %0d actual %0d", exp_r.status, got.status);
                  errs++;
               end
               if (got.steps !== exp_r.steps) begin
                  $error("steps_used expected %0d actual %0d", exp_r.steps, got.steps);
                  errs++;
               end
            end
         end
         error_count <= error_count + errs;
      end
   end
endmodule
`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the polynomial newton root unit
// ----------------------------------------------------------------------------
// programs several polynomials (root-bearing, saturating, constant, zero slope)
// and step limits, sends start points with random gaps and response stalls
`default_nettype none
module tb;
   import pnr_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [31:0] req_tdata = 0;     // start_point
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;         // root[31:0], status[33:32], steps_used[50:34]
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [4:0]  csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          error_count, pending_count;
   bit          stim_done = 0;

   polynomial_newton_root_unit u_top (.*);
   pnr_checker u_chk (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // watchdog: worst case is every search running to a step limit of 1000
   initial begin
      #1s;
      $display("FAILURE");
      $finish;
   end

   // response side waits a random number of cycles before each transaction
   initial begin
      int w;
      forever begin
         w = (stim_done || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
         if (w != 0) begin
            rsp_tready <= 0;
            repeat (w) @(posedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
   endtask

   // valid stays high across back-to-back transactions; drain drops it
   task automatic send_start(input logic [31:0] sp);
      int gap;
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= sp;
      do @(posedge clock); while (!req_tready);
   endtask

   // wait for every response before touching csr
   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic load_poly(input logic [31:0] c0, c1, c2, c3, c4, c5,
                            input logic [31:0] tl, input logic [15:0] ms);
      csr_write(3'd0, c0); csr_write(3'd1, c1); csr_write(3'd2, c2);
      csr_write(3'd3, c3); csr_write(3'd4, c4); csr_write(3'd5, c5);
      csr_write(RegTolerance, tl); csr_write(RegMaxSteps, {16'h0, ms});
   endtask

   function automatic logic [31:0] rnd_start();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
         default: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      endcase
   endfunction

   initial begin
      logic [31:0] dir [8];
      dir = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff,
              32'h00010000, 32'hfffe0000, 32'h00030000, 32'h00000001};
      repeat (3) @(posedge clock);
      reset <= 0;

      // reset config: all-zero polynomial converges at once
      send_start(32'h1234_5678);
      drain();

      // x^2 - 4, default-ish limits
      load_poly(32'hfffc0000, 0, 32'h00010000, 0, 0, 0, 32'h40, 16'd100);
      foreach (dir[i]) send_start(dir[i]);   // zero start hits zero slope
      drain();

      // constant, never within tolerance: zero slope; tolerance zero
      load_poly(32'h00050000, 0, 0, 0, 0, 0, 0, 16'd0);
      send_start(32'h0);
      drain();

      // x^2 + 1 has no real root: step limit at extremes 0 and small
      load_poly(32'h00010000, 0, 32'h00010000, 0, 0, 0, 32'h7fffffff >> 20, 16'd0);
      send_start(32'h00020000);
      drain();
      csr_write(RegMaxSteps, 32'd5);
      send_start(32'h00020000);
      send_start(32'h80000000);
      drain();

      // saturating extreme coefficients
      load_poly(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                32'h80000000, 32'h7fffffff, 32'h100, 16'd20);
      foreach (dir[i]) send_start(dir[i]);
      drain();

      // random polynomials, mostly small, with random start points
      for (int ph = 0; ph < 16; ph++) begin
         logic [31:0] c [6];
         foreach (c[k]) c[k] = ($urandom_range(0, 4) == 0) ? $urandom :
                               32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
         if (ph % 4 == 0) begin c[4] = 0; c[5] = 0; end
         load_poly(c[0], c[1], c[2], c[3], c[4], c[5],
                   (ph == 3) ? 32'h7fffffff : $urandom_range(0, 1 << 12),
                   (ph == 7) ? 16'd1000 : 16'($urandom_range(0, 60)));
         repeat (50) send_start(rnd_start());
         drain();
      end

      stim_done = 1;
      if (error_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
`default_nettype wire
